@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL; clock clk, synchronous reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fqs_pkg.sv @@
package fqs_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_FIELD_W = 5;
  localparam int unsigned DEPTH_DEF   = 16;

  typedef logic signed [DATA_W-1:0] data_t;

  // Action codes
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_SRCH = 2'd2;
  localparam logic [1:0] ACT_CLR  = 2'd3;

  localparam data_t DEQ_EMPTY_VAL = -32'sd1;

  typedef struct packed {
    logic [1:0] action;
    data_t      value;
  } in_item_t;

  typedef struct packed {
    data_t                  result_value;
    logic                   found;
    logic                   empty_error;
    logic                   dropped;
    logic [CNT_FIELD_W-1:0] entry_count;
    data_t                  front_value;
    data_t                  rear_value;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } store_ctrl_t;

  typedef struct packed {
    logic  hit;
    logic  is_empty;
    logic  is_full;
    data_t head;
    data_t second;
  } store_stat_t;

endpackage

@@ sv/fqs_store.sv @@
// Shifting entry store: entry 0 is the oldest, valid bits form a thermometer.
module fqs_store import fqs_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  store_ctrl_t ctrl,
  input  data_t       wr_data,
  input  data_t       key,
  output store_stat_t stat
);

  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [DEPTH-1:0] valid_lo;
  logic [DEPTH-1:0] wr_sel;
  logic [DEPTH-1:0] match;
  data_t            entry_r   [DEPTH];
  data_t            shift_src [DEPTH];

  // first free slot sits just above the last valid one
  assign valid_lo = {valid_r[DEPTH-2:0], 1'b1};
  assign wr_sel   = valid_lo & ~valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = '0;
    end else if (ctrl.push) begin
      valid_nxt = valid_lo;
    end else if (ctrl.pop) begin
      valid_nxt = {1'b0, valid_r[DEPTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_mid
      assign shift_src[g] = entry_r[g+1];
    end else begin : g_top
      assign shift_src[g] = entry_r[g];
    end

    always_ff @(posedge clk) begin
      if (ctrl.push && wr_sel[g]) begin
        entry_r[g] <= wr_data;
      end else if (ctrl.pop) begin
        entry_r[g] <= shift_src[g];
      end
    end

    assign match[g] = valid_r[g] && (entry_r[g] == key);
  end

  assign stat.hit      = |match;
  assign stat.is_empty = !valid_r[0];
  assign stat.is_full  = valid_r[DEPTH-1];
  assign stat.head     = entry_r[0];
  assign stat.second   = entry_r[1];

endmodule

@@ sv/fifo_queue_with_search.sv @@
// Channel  | Ports                           | Item
// ---------+---------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data     | in_item_t: action, value
// result   | out_valid, out_ready, out_data  | out_item_t: one per input item
//
// One item a cycle while the result side is not stalling; each result is registered
// and shows in the cycle after its item is taken, from the single result register behind the store update.
// rst_n (synchronous) empties the queue and drops any waiting result.
// A stalled result holds in the output register; a new item is taken in the
// same cycle the waiting result leaves, so back-pressure costs no bubble.
module fifo_queue_with_search import fqs_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned    CntW     = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);

  logic                         in_acc;
  store_ctrl_t                  ctrl;
  store_stat_t                  stat;
  logic [CntW-1:0]              count_r, count_nxt;
  data_t                        rear_r, rear_nxt;
  data_t                        front_sel;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_r, out_nxt;
  logic [CntW+CNT_FIELD_W-1:0]  cnt_ext;
  logic                         deq_on_empty;

  // Take a new item whenever the result register is free or being emptied
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  fqs_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .wr_data (in_data.value),
    .key     (in_data.value),
    .stat    (stat)
  );

  always_comb begin
    ctrl      = '0;
    count_nxt = count_r;
    rear_nxt  = rear_r;
    front_sel = stat.head;
    out_nxt   = '0;
    if (in_acc) begin
      case (in_data.action)
        ACT_ENQ: begin
          // drop the item when every slot is taken
          if (stat.is_full) begin
            out_nxt.dropped = 1'b1;
          end else begin
            ctrl.push = 1'b1;
            count_nxt = count_r + CntOne;
            rear_nxt  = in_data.value;
            if (stat.is_empty) begin
              front_sel = in_data.value;
            end
          end
        end
        ACT_DEQ: begin
          if (stat.is_empty) begin
            out_nxt.result_value = DEQ_EMPTY_VAL;
            out_nxt.empty_error  = 1'b1;
          end else begin
            ctrl.pop             = 1'b1;
            count_nxt            = count_r - CntOne;
            out_nxt.result_value = stat.head;
            front_sel            = stat.second;
          end
        end
        ACT_SRCH: begin
          out_nxt.found = stat.hit;
        end
        ACT_CLR: begin
          // stored values stay put but are no longer counted
          ctrl.clear = 1'b1;
          count_nxt  = '0;
        end
        default: begin
          ctrl.clear = 1'b1;
          count_nxt  = '0;
        end
      endcase
    end
    cnt_ext             = {{CNT_FIELD_W{1'b0}}, count_nxt};
    out_nxt.entry_count = cnt_ext[CNT_FIELD_W-1:0];
    // front and rear read as zero once the queue is empty
    out_nxt.front_value = (count_nxt == '0) ? '0 : front_sel;
    out_nxt.rear_value  = (count_nxt == '0) ? '0 : rear_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold unless a new item lands
  always_ff @(posedge clk) begin
    rear_r <= rear_nxt;
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign deq_on_empty = in_acc && (in_data.action == ACT_DEQ) && stat.is_empty;

`include "assert_macros.svh"

  `FQS_ASSERT_NOW(a_count_range, 1'b1, count_r <= DepthCnt, "entry count above depth")
  `FQS_ASSERT_NOW(a_empty_match, 1'b1, (count_r == '0) == stat.is_empty, "empty mismatch")
  `FQS_ASSERT_NOW(a_full_match, 1'b1, (count_r == DepthCnt) == stat.is_full, "full mismatch")
  `FQS_ASSERT_NEXT(a_deq_empty, deq_on_empty, out_valid_r && out_r.empty_error, "empty deq")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import fqs_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned BURST_LEN    = 40;
  localparam int unsigned RECENT_KEEP  = 24;
  localparam data_t       DATA_MIN     = 32'sh8000_0000;
  localparam data_t       DATA_MAX     = 32'sh7fff_ffff;

  // Traffic flavours for the random part: build the queue up, run it down, or mix.
  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow of the queue, advanced once per accepted item.
  data_t       shadow_ring [QUEUE_DEPTH];
  int unsigned shadow_head  = 0;
  int unsigned shadow_tail  = 0;
  int unsigned shadow_count = 0;

  // Reports still owed by the block, oldest first.
  out_item_t expected_reports[$];
  // Values recently enqueued, so that searches hit now and then.
  data_t     recent_values[$];

  int unsigned mismatch_count    = 0;
  int unsigned cycle_count       = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned hold_off_request  = 0;
  int unsigned hold_off_left     = 0;

  fifo_queue_with_search #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up on a hung run; the limit leaves a wide margin over the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned ring_step(input int unsigned pos);
    return (pos == QUEUE_DEPTH - 1) ? 0 : pos + 1;
  endfunction

  // Apply one action to the shadow queue and return the report it should produce.
  function automatic out_item_t queue_report(input in_item_t item);
    out_item_t   report;
    int unsigned pos;
    report = '0;
    case (item.action)
      ACT_ENQ: begin
        if (shadow_count == QUEUE_DEPTH) begin
          report.dropped = 1'b1;
        end else begin
          shadow_ring[shadow_tail] = item.value;
          shadow_tail = ring_step(shadow_tail);
          shadow_count++;
        end
      end
      ACT_DEQ: begin
        if (shadow_count == 0) begin
          report.result_value = DEQ_EMPTY_VAL;
          report.empty_error  = 1'b1;
        end else begin
          report.result_value = shadow_ring[shadow_head];
          shadow_head = ring_step(shadow_head);
          shadow_count--;
        end
      end
      ACT_SRCH: begin
        // Only counted entries take part; stale values left by a clear do not.
        pos = shadow_head;
        for (int n = 0; n < shadow_count; n++) begin
          if (shadow_ring[pos] == item.value) report.found = 1'b1;
          pos = ring_step(pos);
        end
      end
      default: begin
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_count = 0;
      end
    endcase
    report.entry_count = shadow_count[CNT_FIELD_W-1:0];
    if (shadow_count != 0) begin
      report.front_value = shadow_ring[shadow_head];
      report.rear_value  = shadow_ring[(shadow_tail == 0) ? QUEUE_DEPTH - 1 : shadow_tail - 1];
    end
    return report;
  endfunction

  task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: report %p arrived with nothing outstanding", $realtime, got);
    end else begin
      want = expected_reports.pop_front();
      compare_field("result_value", want.result_value, got.result_value);
      compare_field("found",        want.found,        got.found);
      compare_field("empty_error",  want.empty_error,  got.empty_error);
      compare_field("dropped",      want.dropped,      got.dropped);
      compare_field("entry_count",  want.entry_count,  got.entry_count);
      compare_field("front_value",  want.front_value,  got.front_value);
      compare_field("rear_value",   want.rear_value,   got.rear_value);
    end
  endtask

  // Sample both channels at the rising edge. Predict before checking, so the
  // expectation is already queued whatever the block's latency.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_reports.push_back(queue_report(in_data));
      if (out_valid && out_ready) check_report(out_data);
    end
  end

  // Result side: stall at random, or hold off for a whole requested stretch.
  always @(negedge clk) begin
    if (hold_off_request != 0) begin
      hold_off_left    = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Offer one item from the falling edge and hold it until it is taken. Valid is
  // left high afterwards; the next call either idles it or replaces the payload.
  task automatic send_item(input logic [1:0] action, input data_t value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data.action = action;
    in_data.value  = value;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (action == ACT_ENQ) begin
      recent_values.push_back(value);
      if (recent_values.size() > RECENT_KEEP) void'(recent_values.pop_front());
    end
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return '0;
      3: return -1;
      // Narrow range, so duplicates end up in the queue together.
      4, 5: return data_t'($urandom_range(15));
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_action(input traffic_mix_t mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (roll < 70) return ACT_ENQ;
        if (roll < 85) return ACT_DEQ;
        if (roll < 99) return ACT_SRCH;
        return ACT_CLR;
      end
      MIX_DRAIN: begin
        if (roll < 22) return ACT_ENQ;
        if (roll < 85) return ACT_DEQ;
        if (roll < 99) return ACT_SRCH;
        return ACT_CLR;
      end
      default: begin
        if (roll < 40) return ACT_ENQ;
        if (roll < 73) return ACT_DEQ;
        if (roll < 97) return ACT_SRCH;
        return ACT_CLR;
      end
    endcase
  endfunction

  // Empty dequeue, extreme values, a hit and a miss, and dequeuing the last entry.
  task automatic test_empty_and_extremes();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    send_item(ACT_DEQ,  '0);
    send_item(ACT_ENQ,  DATA_MIN);
    send_item(ACT_ENQ,  DATA_MAX);
    send_item(ACT_SRCH, DATA_MAX);
    send_item(ACT_SRCH, '0);
    send_item(ACT_DEQ,  '0);
    send_item(ACT_DEQ,  '0);
  endtask

  // Fill across the wrap point, overflow, search, then clear and search the stale entries.
  task automatic test_full_and_clear();
    for (int n = 0; n < QUEUE_DEPTH; n++) send_item(ACT_ENQ, data_t'({8{n[3:0]}}));
    send_item(ACT_ENQ,  DATA_MAX);
    send_item(ACT_SRCH, data_t'(32'h7777_7777));
    send_item(ACT_CLR,  data_t'($urandom));
    send_item(ACT_SRCH, data_t'(32'h7777_7777));
  endtask

  // Bursts of random traffic, each burst leaning towards filling, draining or neither.
  task automatic test_random_traffic(input int unsigned items, input int unsigned send_idle,
                                     input int unsigned recv_idle);
    traffic_mix_t mix;
    logic [1:0]   action;
    data_t        value;
    sender_idle_pct   = send_idle;
    receiver_idle_pct = recv_idle;
    mix               = MIX_EVEN;
    for (int n = 0; n < items; n++) begin
      if (n % BURST_LEN == 0) mix = traffic_mix_t'($urandom_range(2));
      action = pick_action(mix);
      if (action == ACT_SRCH && recent_values.size() != 0 && $urandom_range(1))
        value = recent_values[$urandom_range(recent_values.size() - 1)];
      else
        value = pick_value();
      send_item(action, value);
    end
  endtask

  // Stall the result side for a long stretch while items keep coming, so the
  // block backs up and drops in_ready.
  task automatic test_receiver_hold_off();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off_request  = 150;
    for (int n = 0; n < 40; n++) send_item(pick_action(MIX_EVEN), pick_value());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_extremes();
    test_full_and_clear();
    test_random_traffic(620, 36, 48);
    test_random_traffic(620, 48, 36);
    test_random_traffic(620, 0, 0);
    test_receiver_hold_off();

    // Drop valid, wait for every owed report, then keep running briefly to catch strays.
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/fqs_pkg.sv
sv/fqs_store.sv
sv/fifo_queue_with_search.sv
verif/testbench.sv
